[hdl/jse_pkg.sv]
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared types for the controller and the datapath of the escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

  // Width of the per-action character step counter (longest action is six).
  localparam int unsigned STEP_W = 3;
  // Width of the byte count in the scan buffer (zero to four bytes).
  localparam int unsigned CNT_W  = 3;

  // What the byte at the head of the scan buffer turns into.
  typedef enum logic [2:0] {
    KIND_NONE,   // buffer empty
    KIND_PLAIN,  // printable ASCII, copied as is
    KIND_SHORT,  // backslash and a letter or the byte itself
    KIND_UNI,    // backslash-u 00xx escape
    KIND_PASS,   // complete, valid UTF-8 sequence, copied as is
    KIND_HOLD    // valid but unfinished sequence, kept for the next item
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;   // take the input item into the buffer
    logic              push;   // produce one output character
    logic              shift;  // drop the head byte of the buffer
    logic              flush;  // release the pending character as last
    kind_e             kind;   // action being carried out
    logic [STEP_W-1:0] step;   // character index within the action
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e             kind;        // classification of the head byte
    logic [STEP_W-1:0] cnt;         // characters the action produces
    logic              room;        // a character can be produced now
    logic              flush_room;  // the output register can take an item
    logic              pend_valid;  // a character waits to be released
    logic              end_flag;    // the current item ends the string
  } sts_t;

endpackage

`default_nettype wire

[hdl/json_string_escaper_utf8_top.sv]
// ----------------------------------------------------------------------------
// JSON string escaper with UTF-8 validation, top level
// Escapes a byte stream into JSON string text and passes checked UTF-8.
// ----------------------------------------------------------------------------
// Path: an accepted item is scanned, its first character is emitted into the
// pending stage, and it reaches the output register with the next push or the
// final flush. Each item is accepted, then gets one scan per action (plain
// bytes, escapes, passed sequences) plus a final scan, one push per character
// and the flush of the last character; under backpressure the pushes and the
// flush wait. A new item is accepted only once the last one is finished.
// Reset: rst_ni is asynchronous and active low; it empties the scan buffer,
// so nothing is held, and drops the pending and output items.
`default_nettype none

module json_string_escaper_utf8_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire         s_axis_tlast_i,   // string_end
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_char
  output logic        m_axis_tlast_o,   // run_last
  output logic        m_axis_tuser_o    // [0] text_end
);

  jse_pkg::cmd_t cmd;
  jse_pkg::sts_t sts;

  // Controller.
  jse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  jse_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (s_axis_tdata_i),
    .string_end_i (s_axis_tlast_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_char_o   (m_axis_tdata_o),
    .run_last_o   (m_axis_tlast_o),
    .text_end_o   (m_axis_tuser_o),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i)
  );

endmodule

`default_nettype wire

[hdl/jse_dp.sv]
// ----------------------------------------------------------------------------
// JSON string escaper datapath
// Scan buffer, head-byte classifier, character selection, a pending
// character stage and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_dp (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire  [7:0]          in_byte_i,
  input  wire                 string_end_i,
  input  wire jse_pkg::cmd_t  cmd_i,
  output jse_pkg::sts_t       sts_o,
  output logic [7:0]          out_char_o,
  output logic                run_last_o,
  output logic                text_end_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i
);

  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;
  localparam logic [7:0] LEAD_SUR = 8'hed;
  localparam logic [7:0] CONT_TAG = 8'h80;
  localparam logic [7:0] CONT_MSK = 8'hc0;
  localparam logic [7:0] MIN_E0   = 8'ha0;
  localparam logic [7:0] MIN_F0   = 8'h90;

  // Escape letter for the short escapes; quote and backslash map to themselves.
  function automatic logic [7:0] short_letter(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h08:   r = 8'h62;
      8'h0c:   r = 8'h66;
      8'h0a:   r = 8'h6e;
      8'h0d:   r = 8'h72;
      8'h09:   r = 8'h74;
      default: r = c;
    endcase
    return r;
  endfunction

  // Lower-case hex digit.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) r = CH_ZERO + {4'h0, nib};
    else             r = 8'h57 + {4'h0, nib};
    return r;
  endfunction

  // Continuation byte check, with the second-byte range rules.
  function automatic logic follow_ok(input logic [7:0] lead, input logic second,
                                     input logic [7:0] b);
    logic ok;
    ok = ((b & CONT_MSK) == CONT_TAG);
    if (second) begin
      if (lead == LEAD3_LO && b < MIN_E0)  ok = 1'b0;
      if (lead == LEAD_SUR && b >= MIN_E0) ok = 1'b0;
      if (lead == LEAD4_LO && b < MIN_F0)  ok = 1'b0;
      if (lead == LEAD4_HI && b >= MIN_F0) ok = 1'b0;
    end
    return ok;
  endfunction

  // Scan buffer: held bytes of an unfinished sequence, then the new byte.
  logic [3:0][7:0]             buf_q, buf_d;
  logic [jse_pkg::CNT_W-1:0]   n_q, n_d;
  logic                        end_q, end_d;

  // Pending character and output register.
  logic [7:0] pend_char_q, pend_char_d;
  logic       pend_valid_q, pend_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;
  logic       out_end_q, out_end_d;
  logic       out_valid_q, out_valid_d;

  // Classifier signals.
  logic [7:0]                head;
  logic [2:0]                lead_len;
  logic                      seq_ok;
  jse_pkg::kind_e            kind;
  logic [jse_pkg::STEP_W-1:0] cnt;
  logic [7:0]                sel_char;
  logic                      room;
  logic                      flush_room;

  assign head = buf_q[0];

  // Classify the head byte of the buffer.
  always_comb begin
    lead_len = 3'd0;
    if (head >= LEAD2_LO && head <= LEAD2_HI)      lead_len = 3'd2;
    else if (head >= LEAD3_LO && head <= LEAD3_HI) lead_len = 3'd3;
    else if (head >= LEAD4_LO && head <= LEAD4_HI) lead_len = 3'd4;

    seq_ok = 1'b1;
    for (int k = 1; k < 4; k++) begin
      if ((3'(k) < lead_len) && (3'(k) < n_q)) begin
        if (!follow_ok(head, (k == 1), buf_q[k])) seq_ok = 1'b0;
      end
    end

    kind = jse_pkg::KIND_NONE;
    cnt  = '0;
    if (n_q == '0) begin
      kind = jse_pkg::KIND_NONE;
    end else if (!head[7]) begin
      if (head == CH_QUOTE || head == CH_BSL || head == 8'h08 || head == 8'h0c ||
          head == 8'h0a || head == 8'h0d || head == 8'h09) begin
        kind = jse_pkg::KIND_SHORT;
        cnt  = 3'd2;
      end else if (head < CH_SPACE || head == CH_DEL) begin
        kind = jse_pkg::KIND_UNI;
        cnt  = 3'd6;
      end else begin
        kind = jse_pkg::KIND_PLAIN;
        cnt  = 3'd1;
      end
    end else if (lead_len == 3'd0 || !seq_ok) begin
      kind = jse_pkg::KIND_UNI;
      cnt  = 3'd6;
    end else if (n_q >= lead_len) begin
      kind = jse_pkg::KIND_PASS;
      cnt  = lead_len;
    end else if (end_q) begin
      kind = jse_pkg::KIND_UNI;
      cnt  = 3'd6;
    end else begin
      kind = jse_pkg::KIND_HOLD;
    end
  end

  // Character for the current step of the action.
  always_comb begin
    case (cmd_i.kind)
      jse_pkg::KIND_SHORT: sel_char = (cmd_i.step == '0) ? CH_BSL : short_letter(head);
      jse_pkg::KIND_UNI: begin
        case (cmd_i.step)
          3'd0:    sel_char = CH_BSL;
          3'd1:    sel_char = CH_U;
          3'd2:    sel_char = CH_ZERO;
          3'd3:    sel_char = CH_ZERO;
          3'd4:    sel_char = hex_digit(head[7:4]);
          default: sel_char = hex_digit(head[3:0]);
        endcase
      end
      default: sel_char = head;
    endcase
  end

  assign room       = !pend_valid_q || !out_valid_q || out_ready_i;
  assign flush_room = !out_valid_q || out_ready_i;

  // Buffer update: load appends at the fill count, shift drops the head.
  always_comb begin
    buf_d = buf_q;
    n_d   = n_q;
    end_d = end_q;
    if (cmd_i.load) begin
      buf_d[n_q[1:0]] = in_byte_i;
      n_d             = n_q + 3'd1;
      end_d           = string_end_i;
    end else if (cmd_i.shift) begin
      buf_d = {8'h00, buf_q[3:1]};
      n_d   = n_q - 3'd1;
    end
  end

  // Pending stage and output register.
  always_comb begin
    pend_char_d  = pend_char_q;
    pend_valid_d = pend_valid_q;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    out_end_d    = out_end_q;
    out_valid_d  = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if ((cmd_i.push && pend_valid_q) || cmd_i.flush) begin
      out_valid_d = 1'b1;
      out_char_d  = pend_char_q;
      out_last_d  = cmd_i.flush;
      out_end_d   = cmd_i.flush & end_q;
    end
    if (cmd_i.push) begin
      pend_char_d  = sel_char;
      pend_valid_d = 1'b1;
    end else if (cmd_i.flush) begin
      pend_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q          <= '0;
      end_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      n_q          <= n_d;
      end_q        <= end_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    buf_q       <= buf_d;
    pend_char_q <= pend_char_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_end_q   <= out_end_d;
  end

  assign sts_o.kind       = kind;
  assign sts_o.cnt        = cnt;
  assign sts_o.room       = room;
  assign sts_o.flush_room = flush_room;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.end_flag   = end_q;

  assign out_char_o  = out_char_q;
  assign run_last_o  = out_last_q;
  assign text_end_o  = out_end_q;
  assign out_valid_o = out_valid_q;

  // The buffer never holds more than four bytes.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= 3'd4) else $error("scan buffer overfilled");

  // A load only happens when at most three bytes are held.
  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (n_q <= 3'd3)) else $error("load into a full buffer");

  // A character is only produced when the pending stage can move on.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> room) else $error("character produced without room");

endmodule

`default_nettype wire

[hdl/jse_ctrl.sv]
// ----------------------------------------------------------------------------
// JSON string escaper controller
// Steps through the actions for the buffered bytes of one item and
// sequences the character steps of each action.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire jse_pkg::sts_t  sts_i,
  output jse_pkg::cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_FINISH
  } state_e;

  state_e                      state_q, state_d;
  jse_pkg::kind_e              kind_q, kind_d;
  logic [jse_pkg::STEP_W-1:0]  cnt_q, cnt_d;
  logic [jse_pkg::STEP_W-1:0]  step_q, step_d;
  logic                        last_step;

  assign last_step = (step_q == cnt_q - 3'd1);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.kind == jse_pkg::KIND_NONE || sts_i.kind == jse_pkg::KIND_HOLD) begin
          state_d = ST_FINISH;
        end else begin
          kind_d  = sts_i.kind;
          cnt_d   = sts_i.cnt;
          step_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.room) begin
          if (last_step) state_d = ST_SCAN;
          else           step_d  = step_q + 3'd1;
        end
      end
      ST_FINISH: begin
        if (!sts_i.pend_valid || sts_i.flush_room) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and action registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= jse_pkg::KIND_NONE;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  // Commands to the datapath.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cmd_o.load  = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.push  = (state_q == ST_EMIT) && sts_i.room;
  assign cmd_o.shift = cmd_o.push && ((kind_q == jse_pkg::KIND_PASS) || last_step);
  assign cmd_o.flush = (state_q == ST_FINISH) && sts_i.pend_valid && sts_i.flush_room;
  assign cmd_o.kind  = kind_q;
  assign cmd_o.step  = step_q;

  // The step counter stays within the action.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (step_q < cnt_q)) else $error("step beyond action");

  // A sequence is never held back once the string has ended.
  a_no_hold_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && sts_i.kind == jse_pkg::KIND_HOLD) |-> !sts_i.end_flag)
    else $error("sequence held at end of string");

  // A passed-through sequence is two to four bytes long.
  a_pass_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && kind_q == jse_pkg::KIND_PASS) |-> (cnt_q >= 3'd2 && cnt_q <= 3'd4))
    else $error("bad pass-through length");

endmodule

`default_nettype wire
